### sv/alt_pkg.sv
// ----------------------------------------------------------------------------
// alt_pkg
// shared constants, codes and types of the array list table
// ----------------------------------------------------------------------------
package alt_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 3;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PRED   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SUCC   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd5;
    localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_PRED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NO_SUCC   = 3'd5;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } t_mem_req;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value_out;
        logic [POS_W-1:0]         position_out;
        logic [POS_W-1:0]         list_length;
        logic                     is_empty;
    } t_result;

endpackage

### sv/alt_req_if.sv
// ----------------------------------------------------------------------------
// alt_req_if
// request channel of the array list table
// ----------------------------------------------------------------------------
interface alt_req_if;
    import alt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output req_type, output position, output item_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input item_value,
                    output ready);
endinterface

### sv/alt_rsp_if.sv
// ----------------------------------------------------------------------------
// alt_rsp_if
// result channel of the array list table
// ----------------------------------------------------------------------------
interface alt_rsp_if;
    import alt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value_out;
    logic [POS_W-1:0]         position_out;
    logic [POS_W-1:0]         list_length;
    logic                     is_empty;

    modport source (output valid, output status, output value_out, output position_out,
                    output list_length, output is_empty, input ready);
    modport sink   (input valid, input status, input value_out, input position_out,
                    input list_length, input is_empty, output ready);
endinterface

### sv/array_list_table_core.sv
// ----------------------------------------------------------------------------
// array_list_table_core
// bounded list of signed 32-bit values with 1-based positions
// ----------------------------------------------------------------------------
// request beats arrive on i_req (req_type, position, item_value), one result
// beat per request leaves on o_rsp (status, value_out, position_out,
// list_length, is_empty); both channels use a valid/ready handshake
// one request is worked on at a time; i_req.ready is high only while the
// sequencer is idle, and a result parked in the output register does not
// hold off the next request
// the store is walked one entry a cycle: locate, predecessor and successor
// read entries from the head until a match or the end of the list, then
// fetch the neighbor where one is asked for; get reads one entry; insert at
// p moves the entries from the end down to p up by one and writes p; delete
// at p moves the entries after p down by one; clear, bad position and full
// answer without touching the store
// reset empties the list at once; the store itself is not cleared
// when the receiver stalls the result waits in the output register and a
// second finished result waits in the sequencer, which then stops
// ----------------------------------------------------------------------------
module array_list_table_core (
    input  logic    i_clk,
    input  logic    i_rst_n,
    alt_req_if.sink   i_req,
    alt_rsp_if.source o_rsp
);
    import alt_pkg::*;

    t_mem_req                 mem_req;
    logic signed [DATA_W-1:0] rdata;
    logic                     res_valid;
    logic                     res_ready;
    t_result                  res;

    logic    r_out_valid;
    t_result r_out;

    alt_mem u_mem (
        .i_clk   (i_clk),
        .i_mem   (mem_req),
        .o_rdata (rdata)
    );

    alt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem       (mem_req),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.value_out    = r_out.value_out;
    assign o_rsp.position_out = r_out.position_out;
    assign o_rsp.list_length  = r_out.list_length;
    assign o_rsp.is_empty     = r_out.is_empty;

endmodule

### sv/alt_mem.sv
// ----------------------------------------------------------------------------
// alt_mem
// element store: one write port, one registered read port
// ----------------------------------------------------------------------------
module alt_mem (
    input  logic              i_clk,
    input  alt_pkg::t_mem_req i_mem,
    output logic signed [alt_pkg::DATA_W-1:0] o_rdata
);
    import alt_pkg::*;

    logic signed [DATA_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_mem.raddr];
    end

endmodule

### sv/alt_seq.sv
// ----------------------------------------------------------------------------
// alt_seq
// request sequencer: range checks, pipelined scan and shift over the store
// ----------------------------------------------------------------------------
module alt_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    alt_req_if.sink            i_req,
    output alt_pkg::t_mem_req  o_mem,
    input  logic signed [alt_pkg::DATA_W-1:0] i_rdata,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output alt_pkg::t_result   o_res
);
    import alt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_SHUP  = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_SHDN  = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [ADDR_W-1:0]        r_wt, n_wt;
    logic                     r_chk, n_chk;
    logic [REQ_W-1:0]         r_req, n_req;
    logic [CMP_W-1:0]         r_pos, n_pos;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic [STAT_W-1:0]        r_status, n_status;
    logic signed [DATA_W-1:0] r_vout, n_vout;
    logic [POS_W-1:0]         r_pout, n_pout;

    logic             accept;
    logic [CMP_W-1:0] in_pos;
    logic [CMP_W-1:0] in_pos_m1;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] idx_x;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] idx_m2;
    logic             hit;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign in_pos      = CMP_W'(i_req.position);
    assign in_pos_m1   = in_pos - CMP_W'(1);
    assign cnt_x       = CMP_W'(r_cnt);
    assign pos_m1      = r_pos - CMP_W'(1);
    assign idx_x       = CMP_W'(r_idx);
    assign idx_m1      = r_idx - CNT_W'(1);
    assign idx_m2      = r_idx - CNT_W'(2);
    assign hit         = r_chk && (i_rdata == r_val);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_wt     = r_wt;
        n_chk    = r_chk;
        n_req    = r_req;
        n_pos    = r_pos;
        n_val    = r_val;
        n_addr   = r_addr;
        n_status = r_status;
        n_vout   = r_vout;
        n_pout   = r_pout;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_wt;
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req    = i_req.req_type;
                    n_pos    = in_pos;
                    n_val    = i_req.item_value;
                    n_status = ST_OK;
                    n_vout   = '0;
                    n_pout   = '0;
                    n_idx    = '0;
                    n_chk    = 1'b0;
                    n_state  = S_RESP;
                    case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_cnt = '0;
                        end
                        REQ_GET: begin
                            if (in_pos == '0 || in_pos > cnt_x) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_addr  = in_pos_m1[ADDR_W-1:0];
                                n_state = S_READ;
                            end
                        end
                        REQ_PRED, REQ_SUCC, REQ_LOCATE: begin
                            n_state = S_SCAN;
                        end
                        REQ_INSERT: begin
                            if (in_pos == '0 || in_pos > cnt_x + CMP_W'(1)) begin
                                n_status = ST_BAD_POS;
                            end else if (cnt_x >= CMP_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = r_cnt;
                                n_state = S_SHUP;
                            end
                        end
                        REQ_DELETE: begin
                            if (in_pos == '0 || in_pos > cnt_x) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_idx   = in_pos[CNT_W-1:0];
                                n_state = S_SHDN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_mem.raddr = r_idx[ADDR_W-1:0];
                if (hit) begin
                    n_chk   = 1'b0;
                    n_state = S_RESP;
                    case (r_req)
                        REQ_LOCATE: begin
                            n_pout = idx_x[POS_W-1:0];
                        end
                        REQ_PRED: begin
                            if (r_idx == CNT_W'(1)) begin
                                n_status = ST_NO_PRED;
                            end else begin
                                n_addr  = idx_m2[ADDR_W-1:0];
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            if (r_idx >= r_cnt) begin
                                n_status = ST_NO_SUCC;
                            end else begin
                                n_addr  = r_idx[ADDR_W-1:0];
                                n_state = S_READ;
                            end
                        end
                    endcase
                end else if (r_idx >= r_cnt) begin
                    n_chk    = 1'b0;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                    n_chk = 1'b1;
                end
            end
            S_READ: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_vout  = i_rdata;
                n_state = S_RESP;
            end
            S_SHUP: begin
                o_mem.we    = r_chk;
                o_mem.raddr = idx_m1[ADDR_W-1:0];
                if (idx_x >= r_pos) begin
                    n_wt  = r_idx[ADDR_W-1:0];
                    n_idx = idx_m1;
                    n_chk = 1'b1;
                end else begin
                    n_chk   = 1'b0;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = pos_m1[ADDR_W-1:0];
                o_mem.wdata = r_val;
                n_cnt       = r_cnt + CNT_W'(1);
                n_state     = S_RESP;
            end
            S_SHDN: begin
                o_mem.we    = r_chk;
                o_mem.raddr = r_idx[ADDR_W-1:0];
                if (r_idx < r_cnt) begin
                    n_wt  = idx_m1[ADDR_W-1:0];
                    n_idx = r_idx + CNT_W'(1);
                    n_chk = 1'b1;
                end else begin
                    n_chk   = 1'b0;
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wt     <= n_wt;
        r_req    <= n_req;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_pout   <= n_pout;
    end

    assign o_res_valid        = (r_state == S_RESP);
    assign o_res.status       = r_status;
    assign o_res.value_out    = r_vout;
    assign o_res.position_out = r_pout;
    assign o_res.list_length  = cnt_x[POS_W-1:0];
    assign o_res.is_empty     = (r_cnt == '0);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after a request beat");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_CLEAR) |=> (r_cnt == '0))
        else $error("clear left entries behind");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (r_state == S_SHUP || r_state == S_SHDN || r_state == S_PUT))
        else $error("store written outside insert or delete");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the array list table core
// ----------------------------------------------------------------------------
// a short table of directed requests (empty list, extreme values, every
// request code, each error status but full) runs first, then random sessions
// that grow the list to capacity, probe it while full and drain it again.
// every accepted request is run through a behavioral list kept in the bench
// and each result beat is compared field by field with the oldest
// expected result, the table's own where a row gives one. the sender and the
// receiver idle at random, and the rates change from one phase to the next.
// ----------------------------------------------------------------------------
module tb_top;
    import alt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int ITEMS_PER_PHASE = 332;
    localparam int QUIET_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 150;

    typedef struct {
        logic [REQ_W-1:0]         req;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        t_result                  want;
    } t_probe;

    logic i_clk = 1'b0;
    logic i_rst_n;

    alt_req_if req_bus ();
    alt_rsp_if rsp_bus ();

    array_list_table_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic signed [DATA_W-1:0] list_store [CAPACITY];
    int                       list_count;
    t_result                  pending_results [$];
    t_probe                   probe_rows [$];
    int                       mismatch_count;
    int                       send_idle_pct;
    int                       rsp_stall_pct;
    int                       quiet_cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_result apply_request(input logic [REQ_W-1:0] req,
                                              input logic [POS_W-1:0] pos,
                                              input logic signed [DATA_W-1:0] val);
        t_result r;
        int      hit;
        int      k;
        r   = '0;
        hit = 0;
        while (hit < list_count && list_store[hit] != val)
            hit++;
        case (req)
            REQ_CLEAR: begin
                list_count = 0;
            end
            REQ_GET: begin
                if (pos < 1 || pos > list_count)
                    r.status = ST_BAD_POS;
                else
                    r.value_out = list_store[pos - 1];
            end
            REQ_PRED: begin
                if (hit >= list_count)
                    r.status = ST_NOT_FOUND;
                else if (hit == 0)
                    r.status = ST_NO_PRED;
                else
                    r.value_out = list_store[hit - 1];
            end
            REQ_SUCC: begin
                if (hit >= list_count)
                    r.status = ST_NOT_FOUND;
                else if (hit + 1 >= list_count)
                    r.status = ST_NO_SUCC;
                else
                    r.value_out = list_store[hit + 1];
            end
            REQ_INSERT: begin
                if (pos < 1 || pos > list_count + 1)
                    r.status = ST_BAD_POS;
                else if (list_count >= CAPACITY)
                    r.status = ST_FULL;
                else begin
                    for (k = list_count; k >= pos; k--)
                        list_store[k] = list_store[k - 1];
                    list_store[pos - 1] = val;
                    list_count++;
                end
            end
            REQ_DELETE: begin
                if (pos < 1 || pos > list_count)
                    r.status = ST_BAD_POS;
                else begin
                    for (k = pos; k < list_count; k++)
                        list_store[k - 1] = list_store[k];
                    list_count--;
                end
            end
            REQ_LOCATE: begin
                if (hit >= list_count)
                    r.status = ST_NOT_FOUND;
                else
                    r.position_out = POS_W'(hit + 1);
            end
            default: begin
            end
        endcase
        r.list_length = POS_W'(list_count);
        r.is_empty    = (list_count == 0);
        return r;
    endfunction

    function automatic void table_row(input logic [REQ_W-1:0] req,
                                      input logic [POS_W-1:0] pos,
                                      input logic signed [DATA_W-1:0] val,
                                      input bit typed,
                                      input logic [STAT_W-1:0] status,
                                      input logic signed [DATA_W-1:0] vout,
                                      input logic [POS_W-1:0] pout,
                                      input logic [POS_W-1:0] len,
                                      input logic empty);
        t_probe row;
        row.req                = req;
        row.pos                = pos;
        row.val                = val;
        row.typed              = typed;
        row.want.status        = status;
        row.want.value_out     = vout;
        row.want.position_out  = pout;
        row.want.list_length   = len;
        row.want.is_empty      = empty;
        probe_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val,
                                input bit typed,
                                input t_result want);
        t_result predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= req;
        req_bus.position   <= pos;
        req_bus.item_value <= val;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        predicted = apply_request(req, pos, val);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic random_request(input bit filling);
        int                       roll;
        logic [REQ_W-1:0]         req;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        roll = $urandom_range(99);
        if (filling) begin
            if (roll < 55)      req = REQ_INSERT;
            else if (roll < 62) req = REQ_DELETE;
            else if (roll < 72) req = REQ_GET;
            else if (roll < 80) req = REQ_PRED;
            else if (roll < 87) req = REQ_SUCC;
            else if (roll < 97) req = REQ_LOCATE;
            else                req = REQ_UNUSED;
        end else begin
            if (roll < 45)      req = REQ_DELETE;
            else if (roll < 58) req = REQ_INSERT;
            else if (roll < 68) req = REQ_GET;
            else if (roll < 76) req = REQ_PRED;
            else if (roll < 84) req = REQ_SUCC;
            else if (roll < 94) req = REQ_LOCATE;
            else if (roll < 96) req = REQ_CLEAR;
            else                req = REQ_UNUSED;
        end

        // mostly legal positions, now and then any 8-bit value
        if ($urandom_range(9) == 0)
            pos = POS_W'($urandom);
        else if (req == REQ_INSERT)
            pos = POS_W'($urandom_range(list_count + 1, 1));
        else if (req == REQ_GET || req == REQ_DELETE)
            pos = POS_W'((list_count > 0) ? $urandom_range(list_count, 1)
                                          : $urandom_range(3));
        else
            pos = POS_W'($urandom);

        // searches mostly hit a stored value; small values make duplicates
        if ((req == REQ_PRED || req == REQ_SUCC || req == REQ_LOCATE) &&
            list_count > 0 && $urandom_range(9) < 7)
            val = list_store[$urandom_range(list_count - 1)];
        else if ($urandom_range(1) == 1)
            val = int'($urandom_range(15)) - 8;
        else
            val = $urandom;

        send_request(req, pos, val, 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin : check_beat
        t_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (rsp_bus.status !== want.status)
                    report_mismatch($sformatf("status: got %0d, expected %0d",
                                              rsp_bus.status, want.status));
                if (rsp_bus.value_out !== want.value_out)
                    report_mismatch($sformatf("value_out: got %0d, expected %0d",
                                              rsp_bus.value_out, want.value_out));
                if (rsp_bus.position_out !== want.position_out)
                    report_mismatch($sformatf("position_out: got %0d, expected %0d",
                                              rsp_bus.position_out, want.position_out));
                if (rsp_bus.list_length !== want.list_length)
                    report_mismatch($sformatf("list_length: got %0d, expected %0d",
                                              rsp_bus.list_length, want.list_length));
                if (rsp_bus.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty: got %0d, expected %0d",
                                              rsp_bus.is_empty, want.is_empty));
            end
        end
    end

    // stall watchdog: cycles without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) ||
            (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;
        bit filling;
        int since_full;
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_CLEAR;
        req_bus.position   = '0;
        req_bus.item_value = '0;
        send_idle_pct      = 0;
        rsp_stall_pct      = 0;
        list_count         = 0;
        foreach (list_store[i])
            list_store[i] = '0;

        // empty list, error codes, extreme values, every request code
        table_row(REQ_GET,    8'd1,   32'sd0,           1, ST_BAD_POS,   0, 0, 0, 1);
        table_row(REQ_DELETE, 8'd0,   32'sd0,           1, ST_BAD_POS,   0, 0, 0, 1);
        table_row(REQ_LOCATE, 8'd0,   32'sh7fffffff,    1, ST_NOT_FOUND, 0, 0, 0, 1);
        table_row(REQ_PRED,   8'd0,   32'sd0,           1, ST_NOT_FOUND, 0, 0, 0, 1);
        table_row(REQ_SUCC,   8'd0,   32'sd0,           1, ST_NOT_FOUND, 0, 0, 0, 1);
        table_row(REQ_INSERT, 8'd0,   32'sd5,           1, ST_BAD_POS,   0, 0, 0, 1);
        table_row(REQ_INSERT, 8'd2,   32'sd5,           1, ST_BAD_POS,   0, 0, 0, 1);
        table_row(REQ_INSERT, 8'd1,   32'sh80000000,    1, ST_OK,        0, 0, 1, 0);
        table_row(REQ_INSERT, 8'd2,   32'sh7fffffff,    1, ST_OK,        0, 0, 2, 0);
        table_row(REQ_INSERT, 8'd1,   -32'sd1,          1, ST_OK,        0, 0, 3, 0);
        table_row(REQ_GET,    8'd3,   32'sd0,           0, ST_OK,        0, 0, 0, 0);
        table_row(REQ_GET,    8'd255, 32'sd0,           1, ST_BAD_POS,   0, 0, 3, 0);
        table_row(REQ_GET,    8'd4,   32'sd0,           1, ST_BAD_POS,   0, 0, 3, 0);
        table_row(REQ_PRED,   8'd0,   -32'sd1,          1, ST_NO_PRED,   0, 0, 3, 0);
        table_row(REQ_SUCC,   8'd0,   32'sh7fffffff,    1, ST_NO_SUCC,   0, 0, 3, 0);
        table_row(REQ_PRED,   8'd0,   32'sh7fffffff,    0, ST_OK,        0, 0, 0, 0);
        table_row(REQ_SUCC,   8'd0,   -32'sd1,          0, ST_OK,        0, 0, 0, 0);
        table_row(REQ_LOCATE, 8'd0,   32'sh80000000,    0, ST_OK,        0, 0, 0, 0);
        table_row(REQ_LOCATE, 8'd0,   32'sd0,           1, ST_NOT_FOUND, 0, 0, 3, 0);
        table_row(REQ_UNUSED, 8'd255, -32'sd1,          1, ST_OK,        0, 0, 3, 0);
        table_row(REQ_DELETE, 8'd4,   32'sd0,           1, ST_BAD_POS,   0, 0, 3, 0);
        table_row(REQ_INSERT, 8'd5,   32'sd9,           1, ST_BAD_POS,   0, 0, 3, 0);
        table_row(REQ_DELETE, 8'd1,   32'sd0,           0, ST_OK,        0, 0, 0, 0);
        table_row(REQ_INSERT, 8'd3,   32'sd0,           0, ST_OK,        0, 0, 0, 0);
        table_row(REQ_CLEAR,  8'd0,   32'sd0,           1, ST_OK,        0, 0, 0, 1);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (probe_rows[i])
            send_request(probe_rows[i].req, probe_rows[i].pos, probe_rows[i].val,
                         probe_rows[i].typed, probe_rows[i].want);

        // sessions: fill to capacity, hammer the full list, then drain
        filling    = 1'b1;
        since_full = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
                default: begin send_idle_pct = 23; rsp_stall_pct = 23; end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                if (filling && list_count == CAPACITY)
                    since_full++;
                if (filling && since_full > 12) begin
                    filling    = 1'b0;
                    since_full = 0;
                end else if (!filling && list_count == 0) begin
                    filling = 1'b1;
                end
                random_request(filling);
            end
        end

        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
